// ----- hdl/ccb_pkg.sv -----
`default_nettype none
package ccb_pkg;

  localparam int unsigned PosWidth   = 31;
  localparam int unsigned ChromWidth = 16;
  localparam int unsigned OutCovWidth = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned LenWidth   = 7;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CfgGapSpacing = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgTrimLevel  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgMinPeak    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgMinLength  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgMaxLength  = 3'd4;

  typedef struct packed {
    logic                  kind;
    logic [PosWidth-1:0]   read_start;
    logic [PosWidth-1:0]   read_end;
    logic                  read_strand;
    logic [ChromWidth-1:0] chrom_id;
  } in_item_t;

  typedef struct packed {
    logic                   status;
    logic [ChromWidth-1:0]  out_chrom;
    logic [PosWidth-1:0]    region_start;
    logic [PosWidth-1:0]    region_end;
    logic                   out_strand;
    logic [OutCovWidth-1:0] coverage;
    logic                   last;
  } out_item_t;

  // Decision taken by the front part on one item.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_DROP,
    OP_BUMP,
    OP_EXTEND,
    OP_CLOSE_SEED,
    OP_SEED,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [PosWidth-1:0]   read_start;
    logic [PosWidth-1:0]   read_end;
    logic                  read_strand;
    logic [ChromWidth-1:0] chrom_id;
    logic [PosWidth-1:0]   contig_first;
    logic [PosWidth-1:0]   contig_last;
    logic [ChromWidth-1:0] contig_chrom;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZERO,
    ST_BUMP,
    ST_SCAN,
    ST_TAIL,
    ST_CHECK,
    ST_EMIT,
    ST_SEED,
    ST_DROP
  } back_state_t;

endpackage
`default_nettype wire

// ----- hdl/ccb_front.sv -----
`default_nettype none
module ccb_front #(
  parameter int unsigned CONTIG_DEPTH = 1024
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        take,
  input  wire ccb_pkg::in_item_t     item,
  input  wire [9:0]                  gap_spacing,
  output ccb_pkg::cmd_t              cmd
);
  import ccb_pkg::*;

  logic                  contig_valid;
  logic [PosWidth-1:0]   contig_first;
  logic [PosWidth-1:0]   contig_last;
  logic [ChromWidth-1:0] contig_chrom;

  logic [PosWidth:0] lim;
  logic [PosWidth:0] ext_len;
  logic [PosWidth:0] seed_len;
  logic              in_span;
  logic              extend;
  op_t               op;

  // Classify the item against the contig held here.
  always_comb begin
    lim      = {1'b0, contig_last} + {{(PosWidth-9){1'b0}}, gap_spacing};
    ext_len  = {1'b0, item.read_end} - {1'b0, contig_first} + 1'b1;
    seed_len = {1'b0, item.read_end} - {1'b0, item.read_start} + 1'b1;
    in_span  = contig_valid && item.read_end <= contig_last
               && item.read_end > contig_first;
    extend   = contig_valid && {1'b0, item.read_start} <= lim
               && item.read_end > contig_first;
    if (item.kind) begin
      op = contig_valid ? OP_FLUSH : OP_NONE;
    end else if (in_span) begin
      op = OP_BUMP;
    end else if (extend) begin
      op = (ext_len > (PosWidth+1)'(CONTIG_DEPTH)) ? OP_DROP : OP_EXTEND;
    end else if (item.read_end < item.read_start
                 || seed_len > (PosWidth+1)'(CONTIG_DEPTH)) begin
      op = OP_DROP;
    end else begin
      op = contig_valid ? OP_CLOSE_SEED : OP_SEED;
    end
    cmd.op           = op;
    cmd.read_start   = item.read_start;
    cmd.read_end     = item.read_end;
    cmd.read_strand  = item.read_strand;
    cmd.chrom_id     = item.chrom_id;
    cmd.contig_first = contig_first;
    cmd.contig_last  = contig_last;
    cmd.contig_chrom = contig_chrom;
  end

  // Contig bookkeeping, updated as each item is passed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      contig_valid <= 1'b0;
      contig_first <= '0;
      contig_last  <= '0;
      contig_chrom <= '0;
    end else if (take) begin
      unique case (op)
        OP_FLUSH: contig_valid <= 1'b0;
        OP_EXTEND: contig_last <= item.read_end;
        OP_SEED, OP_CLOSE_SEED: begin
          contig_valid <= 1'b1;
          contig_first <= item.read_start;
          contig_last  <= item.read_end;
          contig_chrom <= item.chrom_id;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/ccb_queue.sv -----
`default_nettype none
module ccb_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  wire ccb_pkg::cmd_t push_data,
  input  wire            pop,
  output ccb_pkg::cmd_t  head,
  output logic           not_empty,
  output logic           full
);
  import ccb_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign head      = slot[rd_ptr];
  assign not_empty = fill != 2'd0;
  assign full      = fill == 2'd2;

  // Two-entry command queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end
endmodule
`default_nettype wire

// ----- hdl/ccb_back.sv -----
`default_nettype none
module ccb_back #(
  parameter int unsigned CONTIG_DEPTH = 1024,
  parameter int unsigned MAX_EMIT     = 64,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 have_cmd,
  input  wire ccb_pkg::cmd_t  cmd,
  output logic                pop,
  input  wire [15:0]          trim_level,
  input  wire [15:0]          min_peak,
  input  wire [6:0]           min_length,
  input  wire [6:0]           max_length,
  output logic                result_valid,
  output ccb_pkg::out_item_t  result
);
  import ccb_pkg::*;

  localparam int unsigned AW = $clog2(CONTIG_DEPTH);
  localparam int unsigned IW = AW + 1;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  back_state_t state, state_next;

  logic [COUNT_WIDTH-1:0] mem [CONTIG_DEPTH];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [AW-1:0]          rd_addr;
  logic                   rd_en;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;

  cmd_t          cur;
  logic [IW-1:0] idx;       // next address to issue
  logic [IW-1:0] stop;      // last address of the sweep
  logic          rd_pend;   // rd_data holds the entry at pend_addr
  logic [IW-1:0] pend_addr;
  logic          busy_rmw;
  logic [COUNT_WIDTH-1:0] peak;
  logic          found;
  logic [IW-1:0] s_idx;
  logic [IW-1:0] e_idx;
  logic [IW-1:0] emit_n;
  logic [IW-1:0] tlen;
  logic          emit_ok;
  logic          above;
  logic [PosWidth-1:0] bump_lo;

  // Coverage store with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_comb begin
    tlen    = e_idx - s_idx + 1'b1;
    above   = 32'(rd_data) > 32'(trim_level);
    emit_ok = found && 32'(peak) >= 32'(min_peak)
              && 32'(tlen) >= 32'(min_length) && 32'(tlen) <= 32'(max_length)
              && 32'(tlen) <= 32'(MAX_EMIT);
    bump_lo = (cmd.read_start < cmd.contig_first) ? cmd.contig_first : cmd.read_start;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (have_cmd) begin
        unique case (cmd.op)
          OP_DROP: state_next = ST_DROP;
          OP_BUMP: state_next = (cmd.read_start > cmd.read_end) ? ST_IDLE : ST_BUMP;
          OP_EXTEND: state_next = ST_ZERO;
          OP_CLOSE_SEED, OP_FLUSH: state_next = ST_SCAN;
          OP_SEED: state_next = ST_SEED;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_ZERO: if (idx == stop) state_next =
                 (cur.read_start > cur.read_end) ? ST_IDLE : ST_BUMP;
      ST_BUMP: if (!busy_rmw && idx > stop) state_next = ST_IDLE;
      ST_SCAN: if (rd_pend && pend_addr == stop) state_next = ST_TAIL;
      ST_TAIL: if (!found) state_next = ST_CHECK;
               else if (rd_pend && (above || pend_addr == s_idx)) state_next = ST_CHECK;
      ST_CHECK: state_next = emit_ok ? ST_EMIT
                             : (cur.op == OP_CLOSE_SEED ? ST_SEED : ST_IDLE);
      ST_EMIT: if (rd_pend && emit_n == tlen - 1'b1)
                 state_next = (cur.op == OP_CLOSE_SEED) ? ST_SEED : ST_IDLE;
      ST_SEED: if (idx == stop) state_next = ST_IDLE;
      ST_DROP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Store access and results.
  always_comb begin
    pop          = state == ST_IDLE && have_cmd;
    rd_en        = 1'b0;
    rd_addr      = idx[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = idx[AW-1:0];
    wr_data      = '0;
    result_valid = 1'b0;
    result.status       = 1'b0;
    result.out_chrom    = cur.contig_chrom;
    result.region_start = cur.contig_first + PosWidth'(s_idx);
    result.region_end   = cur.contig_first + PosWidth'(e_idx);
    result.out_strand   = cur.read_strand;
    result.coverage     = OutCovWidth'((rd_data > COUNT_WIDTH'(16'hFFFF))
                                       ? COUNT_WIDTH'(16'hFFFF) : rd_data);
    result.last         = emit_n == tlen - 1'b1;
    unique case (state)
      ST_ZERO, ST_SEED: begin
        wr_en   = 1'b1;
        wr_data = (state == ST_SEED) ? COUNT_WIDTH'(1) : '0;
      end
      ST_BUMP: begin
        if (busy_rmw) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr[AW-1:0];
          wr_data = (rd_data == CountMax) ? rd_data : rd_data + 1'b1;
        end else if (idx <= stop) begin
          rd_en = 1'b1;
        end
      end
      ST_SCAN: rd_en = idx <= stop;
      ST_TAIL: rd_en = 1'b1;
      ST_EMIT: rd_en = 1'b1;
      ST_DROP: begin
        result_valid        = 1'b1;
        result.status       = 1'b1;
        result.out_chrom    = cur.chrom_id;
        result.region_start = cur.read_start;
        result.region_end   = cur.read_end;
        result.coverage     = '0;
        result.last         = 1'b1;
      end
      default: ;
    endcase
    if (state == ST_EMIT && rd_pend) result_valid = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_pend  <= 1'b0;
      busy_rmw <= 1'b0;
    end else begin
      state    <= state_next;
      rd_pend  <= rd_en;
      busy_rmw <= (state == ST_BUMP) && !busy_rmw && idx <= stop;
    end
  end

  // Sweep counters and close bookkeeping.
  always_ff @(posedge clk) begin
    pend_addr <= idx;
    unique case (state)
      ST_IDLE: if (have_cmd) begin
        cur <= cmd;
        unique case (cmd.op)
          OP_BUMP: begin
            idx  <= IW'(bump_lo - cmd.contig_first);
            stop <= IW'(cmd.read_end - cmd.contig_first);
          end
          OP_EXTEND: begin
            idx  <= IW'(cmd.contig_last - cmd.contig_first) + 1'b1;
            stop <= IW'(cmd.read_end - cmd.contig_first);
          end
          OP_SEED: begin
            idx  <= '0;
            stop <= IW'(cmd.read_end - cmd.read_start);
          end
          default: begin
            idx  <= '0;
            stop <= IW'(cmd.contig_last - cmd.contig_first);
          end
        endcase
        peak  <= '0;
        found <= 1'b0;
      end
      ST_ZERO: if (idx == stop) begin
        idx <= IW'(((cur.read_start < cur.contig_first) ? cur.contig_first
                    : cur.read_start) - cur.contig_first);
      end else begin
        idx <= idx + 1'b1;
      end
      ST_BUMP: if (busy_rmw) idx <= idx + 1'b1;
      ST_SCAN: begin
        // The last entry has arrived: the backward pass starts from it.
        if (rd_pend && pend_addr == stop) begin
          idx <= stop;
        end else if (idx <= stop) begin
          idx <= idx + 1'b1;
        end
        if (rd_pend) begin
          if (rd_data > peak) peak <= rd_data;
          if (!found && above) begin
            found <= 1'b1;
            s_idx <= pend_addr;
          end
        end
      end
      ST_TAIL: begin
        // One read per cycle walking down; pend_addr trails idx by one.
        idx <= idx - 1'b1;
        if (!found) begin
          e_idx <= '0;
        end else if (rd_pend) begin
          e_idx <= pend_addr;
        end
      end
      ST_CHECK: begin
        emit_n <= '0;
        if (emit_ok) begin
          idx <= cur.read_strand ? e_idx : s_idx;
        end else begin
          idx <= '0;
        end
        if (cur.op == OP_CLOSE_SEED) begin
          stop <= IW'(cur.read_end - cur.read_start);
        end
      end
      ST_EMIT: begin
        if (rd_pend && emit_n == tlen - 1'b1) begin
          idx <= '0;
        end else begin
          idx <= cur.read_strand ? idx - 1'b1 : idx + 1'b1;
        end
        if (rd_pend) emit_n <= emit_n + 1'b1;
      end
      ST_SEED: idx <= idx + 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- hdl/coverage_contig_builder.sv -----
`default_nettype none
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+------------------------------
// input     | start, busy, in_item           | taken when start && !busy
// result    | result_strobe, result_item     | one cycle, cannot be held off
// config    | cfg_write, cfg_index, cfg_data | taken when cfg_write is high
//
// An item's work grows with the coverage entries it touches: a bump reads
// then writes each base of the store, an extension clears its new entries
// and then bumps, a close makes one pass over the contig, a backward trim
// pass and one read per emitted base, and a seed writes each base.
// Reset is synchronous; the store itself is not cleared. Results cannot be
// stalled; busy rises while the two-entry command queue is full.
module coverage_contig_builder #(
  parameter int unsigned CONTIG_DEPTH = 1024,
  parameter int unsigned MAX_EMIT     = 64,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire ccb_pkg::in_item_t in_item,
  output logic                result_strobe,
  output ccb_pkg::out_item_t  result_item,
  input  wire                 cfg_write,
  input  wire [ccb_pkg::CfgIdxWidth-1:0] cfg_index,
  input  wire [ccb_pkg::CfgWidth-1:0]    cfg_data
);
  import ccb_pkg::*;

  logic [9:0]  gap_spacing;
  logic [15:0] trim_level;
  logic [15:0] min_peak;
  logic [LenWidth-1:0] min_length;
  logic [LenWidth-1:0] max_length;

  cmd_t front_cmd;
  cmd_t head;
  logic q_full;
  logic q_ne;
  logic pop;
  logic take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_spacing <= '0;
      trim_level  <= '0;
      min_peak    <= 16'd1;
      min_length  <= 7'd16;
      max_length  <= 7'd64;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CfgGapSpacing: gap_spacing <= cfg_data[9:0];
        CfgTrimLevel:  trim_level  <= cfg_data;
        CfgMinPeak:    min_peak    <= cfg_data;
        CfgMinLength:  min_length  <= cfg_data[6:0];
        CfgMaxLength:  max_length  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign busy = q_full;
  assign take = start && !busy;

  ccb_front #(.CONTIG_DEPTH(CONTIG_DEPTH)) u_front (
    .clk, .rst, .take, .item(in_item), .gap_spacing, .cmd(front_cmd)
  );

  ccb_queue u_queue (
    .clk, .rst, .push(take), .push_data(front_cmd), .pop,
    .head, .not_empty(q_ne), .full(q_full)
  );

  ccb_back #(
    .CONTIG_DEPTH(CONTIG_DEPTH), .MAX_EMIT(MAX_EMIT), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk, .rst, .have_cmd(q_ne), .cmd(head), .pop,
    .trim_level, .min_peak, .min_length, .max_length,
    .result_valid(result_strobe), .result(result_item)
  );
endmodule
`default_nettype wire

// ----- hdl/ccb_checker.sv -----
`default_nettype none
module ccb_checker (
  input wire                    clk,
  input wire                    rst,
  input wire                    busy,
  input wire                    result_strobe,
  input wire ccb_pkg::out_item_t result_item
);
  // A dropped item is always a lone last result with zero coverage.
  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result_item.status |-> result_item.last)
    else $error("drop result without last");
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result_item.status |-> result_item.coverage == 16'd0)
    else $error("drop result with coverage");
  // Within a profile the region stays fixed.
  a_region: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result_item.status && !result_item.last |=>
    !result_strobe || result_item.status
    || result_item.region_start == $past(result_item.region_start))
    else $error("region changed inside profile");
  a_reset: assert property (@(posedge clk) $past(rst) |-> !busy)
    else $error("busy after reset");
endmodule

bind coverage_contig_builder ccb_checker u_checker (
  .clk, .rst, .busy, .result_strobe, .result_item
);
`default_nettype wire

// ----- tb/tb_coverage_contig_builder.sv -----
`default_nettype none
module tb_coverage_contig_builder;
  import ccb_pkg::*;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned EmitMax    = 64;
  localparam longint unsigned CountTop = 65535;
  localparam longint unsigned PosTop   = 64'h7FFF_FFFF;
  // Cycles the block may still spend on an item that yields no result.
  localparam int unsigned SettleCycles = 12000;

  // Predicts the profiles of the contig and checks them in order.
  class contig_scoreboard;
    longint unsigned gap, trim, peak_min, len_min, len_max;
    bit              held;
    longint unsigned first, lastp;
    logic [15:0]     chrom;
    longint unsigned counts [StoreDepth];
    out_item_t       profile_q [$];
    int unsigned     errors, checked, drops;

    function new();
      gap = 0; trim = 0; peak_min = 1; len_min = 16; len_max = 64;
      held = 0; first = 0; lastp = 0; chrom = '0;
      foreach (counts[i]) counts[i] = 0;
      errors = 0; checked = 0; drops = 0;
    endfunction

    function void write_reg(logic [2:0] idx, longint unsigned val);
      case (idx)
        CfgGapSpacing: gap = val & 'h3FF;
        CfgTrimLevel:  trim = val & 'hFFFF;
        CfgMinPeak:    peak_min = val & 'hFFFF;
        CfgMinLength:  len_min = val & 'h7F;
        CfgMaxLength:  len_max = val & 'h7F;
        default: ;
      endcase
    endfunction

    // Adds one over a span, clipped to the contig and to the store.
    function void bump(longint unsigned from, longint unsigned upto);
      longint unsigned p;
      p = (from < first) ? first : from;
      for (; p <= upto; p++) begin
        if (p - first >= StoreDepth) break;
        if (counts[p - first] < CountTop) counts[p - first]++;
      end
    endfunction

    function void push(bit st, longint unsigned chr, longint unsigned rs,
                       longint unsigned re, bit sd, longint unsigned cov, bit lst);
      out_item_t r;
      r.status = st;
      r.out_chrom = chr[15:0];
      r.region_start = rs[30:0];
      r.region_end = re[30:0];
      r.out_strand = sd;
      r.coverage = (cov > CountTop) ? 16'hFFFF : cov[15:0];
      r.last = lst;
      profile_q.push_back(r);
    endfunction

    // Trims the closed contig and queues its profile if it qualifies.
    function void close_profile(bit sd);
      longint unsigned len, s, e, tlen, peak, idx;
      bit found;
      len = lastp - first + 1;
      if (len > StoreDepth) len = StoreDepth;
      s = 0; peak = 0; found = 0;
      for (longint unsigned i = 0; i < len; i++) begin
        if (counts[i] > peak) peak = counts[i];
        if (!found && counts[i] > trim) begin
          found = 1;
          s = i;
        end
      end
      if (!found) return;
      e = len - 1;
      while (e > s && counts[e] <= trim) e--;
      tlen = e - s + 1;
      if (peak < peak_min || tlen < len_min || tlen > len_max || tlen > EmitMax) return;
      for (longint unsigned i = 0; i < tlen; i++) begin
        idx = sd ? e - i : s + i;
        push(0, chrom, first + s, first + e, sd, counts[idx], i + 1 == tlen);
      end
    endfunction

    function void note_item(in_item_t it);
      longint unsigned rs, re;
      rs = it.read_start;
      re = it.read_end;
      if (it.kind) begin
        if (held) close_profile(it.read_strand);
        held = 0;
        return;
      end
      if (held) begin
        if (re <= lastp && re > first) begin
          bump(rs, re);
          return;
        end
        if (rs <= lastp + gap && re > first) begin
          if (re - first + 1 > StoreDepth) begin
            push(1, it.chrom_id, rs, re, it.read_strand, 0, 1);
            drops++;
            return;
          end
          for (longint unsigned i = lastp + 1; i <= re; i++) counts[i - first] = 0;
          lastp = re;
          bump(rs, re);
          return;
        end
      end
      if (re < rs || re - rs + 1 > StoreDepth) begin
        push(1, it.chrom_id, rs, re, it.read_strand, 0, 1);
        drops++;
        return;
      end
      if (held) close_profile(it.read_strand);
      held = 1;
      first = rs;
      lastp = re;
      chrom = it.chrom_id;
      for (longint unsigned i = 0; i < re - rs + 1; i++) counts[i] = 1;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_field(string name, longint unsigned got, longint unsigned want);
      if (got != want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(out_item_t r);
      out_item_t e;
      if (profile_q.size() == 0) begin
        report($sformatf("unexpected result %0h", r));
        return;
      end
      e = profile_q.pop_front();
      checked++;
      if ($isunknown(r)) report($sformatf("unknown bits in result %0h", r));
      check_field("status", r.status, e.status);
      check_field("out_chrom", r.out_chrom, e.out_chrom);
      check_field("region_start", r.region_start, e.region_start);
      check_field("region_end", r.region_end, e.region_end);
      check_field("out_strand", r.out_strand, e.out_strand);
      check_field("coverage", r.coverage, e.coverage);
      check_field("last", r.last, e.last);
    endtask
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      result_strobe;
  out_item_t result_item;
  logic      cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  contig_scoreboard sb = new();
  bit          gaps_on;
  int unsigned sent;

  coverage_contig_builder u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .result_strobe(result_strobe), .result_item(result_item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Generous overall limit.
  initial begin
    #20000000;
    $display("timeout with %0d profile bases outstanding", sb.profile_q.size());
    $display("tb_coverage_contig_builder failed");
    $finish;
  end

  // Results cannot be held off, so every strobe is checked.
  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check_result(result_item);
  end

  // Offers one item and holds it until the block takes it.
  task automatic send_item(bit kind, longint unsigned rs, longint unsigned re,
                           bit sd, logic [15:0] chr);
    in_item_t it;
    it.kind = kind;
    it.read_start = rs[30:0];
    it.read_end = re[30:0];
    it.read_strand = sd;
    it.chrom_id = chr;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    sent++;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic set_regs(int unsigned g, int unsigned t, int unsigned p,
                          int unsigned lmin, int unsigned lmax);
    int unsigned vals [5];
    vals = '{g, t, p, lmin, lmax};
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i][15:0];
      @(posedge clk);
      sb.write_reg(3'(i), vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  // Lets every expected base arrive and the block fall quiet.
  task automatic drain();
    start <= 1'b0;
    while (sb.profile_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic longint unsigned clip(longint unsigned v);
    return (v > PosTop) ? PosTop : v;
  endfunction

  // Mostly well-formed sorted reads around the current contig, some noise.
  task automatic random_items(int unsigned count);
    longint unsigned rs, re, span;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      span = sb.lastp - sb.first;
      if (!sb.held || pick < 15) begin
        rs = clip(sb.lastp + sb.gap + $urandom_range(1, 200));
        if ($urandom_range(0, 9) == 0) rs = PosTop - $urandom_range(0, 2000);
        re = clip(rs + (($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(0, 40)));
        send_item(0, rs, re, $urandom_range(0, 1), 16'($urandom));
      end else if (pick < 55 && span > 0) begin
        re = sb.first + $urandom_range(1, span);
        rs = (re > 8 && $urandom_range(0, 4) == 0) ? re - $urandom_range(0, 8) - span
                                                   : re - $urandom_range(0, re - sb.first);
        send_item(0, rs, re, $urandom_range(0, 1), 16'($urandom));
      end else if (pick < 75) begin
        rs = sb.lastp + $urandom_range(0, sb.gap);
        if (rs > 3 && $urandom_range(0, 3) == 0) rs = rs - $urandom_range(0, 3);
        re = clip(sb.lastp + $urandom_range(1, 30));
        send_item(0, rs, re, $urandom_range(0, 1), 16'($urandom));
      end else if (pick < 83) begin
        send_item(1, $urandom, $urandom, $urandom_range(0, 1), 16'($urandom));
      end else if (pick < 90) begin
        case ($urandom_range(0, 2))
          0: begin rs = clip(sb.lastp + sb.gap + 500); re = rs - $urandom_range(1, 50); end
          1: begin rs = sb.lastp + 3000; re = clip(rs + StoreDepth + $urandom_range(0, 9)); end
          default: begin rs = sb.lastp; re = clip(sb.first + StoreDepth + $urandom_range(0, 3)); end
        endcase
        send_item(0, rs, re, $urandom_range(0, 1), 16'($urandom));
      end else begin
        rs = {$urandom} & PosTop;
        re = ($urandom_range(0, 1)) ? clip(rs + $urandom_range(0, 60)) : ({$urandom} & PosTop);
        send_item($urandom_range(0, 1), rs, re, $urandom_range(0, 1), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    in_item <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    gaps_on = 1;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed reads under the reset register values.
    send_item(1, 0, 0, 0, 16'h0000);                 // flush with no contig
    send_item(0, 100, 119, 0, 16'h0005);             // seed
    send_item(0, 105, 110, 0, 16'h0005);             // bump inside
    send_item(0, 90, 115, 1, 16'h0005);              // span starting before the contig
    send_item(0, 119, 130, 0, 16'h0005);             // extension
    send_item(0, 200, 219, 1, 16'h0007);             // closes, reverse order
    send_item(1, 0, 0, 0, 16'h0000);                 // flush, forward order
    send_item(0, 500, 400, 1, 16'hABCD);             // empty span dropped
    send_item(0, 1000, 2100, 0, 16'h1234);           // too long to seed
    send_item(0, 3000, 3004, 0, 16'h0002);           // short contig
    send_item(0, 3004, 3000 + StoreDepth, 1, 16'h0002); // extension overflow
    send_item(0, 4000, 4063, 0, 16'h0003);           // full-length profile
    send_item(1, 0, 0, 1, 16'h0000);
    send_item(0, 5000, 5064, 0, 16'h0004);           // one base over the limit
    send_item(1, 0, 0, 0, 16'h0000);
    send_item(0, PosTop - 47, PosTop, 1, 16'hFFFF);  // top of the position range
    send_item(0, PosTop - 40, PosTop - 2, 1, 16'hFFFF);
    send_item(1, PosTop, PosTop, 1, 16'hFFFF);
    send_item(0, 0, 0, 0, 16'h0000);                 // single base at zero
    send_item(1, 0, 0, 0, 16'h0000);
    drain();

    // Extremes: wide gap, nothing above the trimming level.
    set_regs(1023, 65535, 0, 5, 6);
    send_item(0, 6000, 6010, 0, 16'h0001);
    send_item(0, 6020, 6012, 0, 16'h0001);           // extension starting past its end
    random_items(20);
    send_item(1, 0, 0, 0, 16'h0000);
    drain();

    // Several looser settings with short profiles allowed; the last without idling.
    set_regs(0, 0, 1, 5, 64);
    random_items(25);
    drain();
    for (int k = 0; k < 3; k++) begin
      if (k == 2) gaps_on = 0;
      set_regs($urandom_range(0, 40), $urandom_range(0, 2), $urandom_range(1, 4),
               $urandom_range(5, 20), $urandom_range(20, 64));
      random_items(20);
      send_item(1, 0, 0, $urandom_range(0, 1), 16'h0000);
      drain();
    end

    $display("Sent %0d items; checked %0d results, %0d of them dropped reads.",
             sent, sb.checked, sb.drops);
    $display("Covered seeding, bumps, extensions, drops, trimming and both base orders.");
    if (sb.errors == 0 && sb.profile_q.size() == 0) begin
      $display("tb_coverage_contig_builder passed");
    end else begin
      $display("tb_coverage_contig_builder failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
